// File: rtl/core/psd_pkg.sv
// Package for the PAM soft demapper: constants, tables and state enum.
package psd_pkg;

  localparam int MaxPointsDefault = 16;
  localparam int SampleW = 16;
  localparam int LlrW = 20;
  localparam int LimitW = 19;
  localparam int ScaleW = 24;
  localparam int SumW = 37;

  localparam logic [1:0] RegBps   = 2'd0;
  localparam logic [1:0] RegLabel = 2'd1;
  localparam logic [1:0] RegScale = 2'd2;
  localparam logic [1:0] RegLimit = 2'd3;

  localparam logic [63:0] Ln2Q32 = 64'd2977044472;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_MIN,
    ST_EXP,
    ST_SUM,
    ST_LOGN,
    ST_LOGSQ,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [1:0] sel;
  } log_req_t;

  typedef logic [20:0][32:0] exp_tab_t;

  // Rounded Q1.12 point magnitudes, indexed as in the sorted list per M.
  function automatic logic [12:0] point_mag(input logic [3:0] idx);
    logic [12:0] v;
    begin
      unique case (idx)
        4'd0:  v = 13'd4096;
        4'd1:  v = 13'd1832;
        4'd2:  v = 13'd5495;
        4'd3:  v = 13'd894;
        4'd4:  v = 13'd2681;
        4'd5:  v = 13'd4469;
        4'd6:  v = 13'd6257;
        4'd7:  v = 13'd444;
        4'd8:  v = 13'd1333;
        4'd9:  v = 13'd2221;
        4'd10: v = 13'd3110;
        4'd11: v = 13'd3998;
        4'd12: v = 13'd4887;
        4'd13: v = 13'd5776;
        4'd14: v = 13'd6664;
        default: v = 13'd0;
      endcase
      return v;
    end
  endfunction

  // exp(-2^(k-16)) in Q0.32, by repeated squaring in Q0.62.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    logic [63:0] c;
    logic [127:0] p;
    begin
      t = '0;
      c = (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
      for (int i = 0; i < 21; i++) begin
        t[i] = 33'((c + (64'd1 << 29)) >> 30);
        p = {64'd0, c} * {64'd0, c};
        c = p[125:62] + {63'd0, p[61]};
      end
      return t;
    end
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

  function automatic logic [32:0] exp_entry(input logic [4:0] k);
    return (k < 5'd21) ? ExpTab[k] : 33'd0;
  endfunction

endpackage

// File: rtl/core/psd_mul.sv
// Shared 37x37 multiplier built from a 37x19 partial product, taken on the low and then the high part of b.
module psd_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [36:0]  a,
  input  logic [36:0]  b,
  output logic         done,
  output logic [73:0]  p
);
  logic        phase;
  logic        run;
  logic [36:0] ra;
  logic [36:0] rb;
  logic [55:0] part;

  assign part = 56'(ra) * 56'(phase ? {1'b0, rb[36:19]} : rb[18:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      run   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        phase <= 1'b0;
        run   <= 1'b1;
        ra    <= a;
        rb    <= b;
        p     <= '0;
      end else if (run && !phase) begin
        p     <= 74'(part);
        phase <= 1'b1;
      end else if (run) begin
        p     <= p + (74'(part) << 19);
        phase <= 1'b0;
        run   <= 1'b0;
        done  <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/pam_soft_demapper_llr_core.sv
// Top level: sequenced log-MAP soft demapper for M-PAM around one shared multiplier.
//  channel | dir | signals
//  in      | in  | in_valid, in_stall, sample
//  out     | out | out_valid, out_stall, llr, bit_index, last
//  cfg     | in  | psel, penable, pwrite, paddr, pwdata, prdata, pready
// Every product on the shared unit goes through issue, two partial products and retire.
// Per sample with M points: 2M products for distances and scaling, then per point
// one product per set bit among the low 21 bits of the exponent difference, then
// per label bit a pass summing the M terms, two log2 runs of 16 products and one
// ln2 product (skipped when a sum is empty). Input stalls while busy.
// Synchronous reset; no clearing pass. Output register holds until not stalled.
module pam_soft_demapper_llr_core #(
  parameter int MAX_POINTS = psd_pkg::MaxPointsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [19:0] llr,
  output logic [1:0]  bit_index,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int MaxBits = $clog2(MAX_POINTS + 1) - 1;

  logic [2:0]  bps;
  logic [63:0] label_table;
  logic [23:0] scale;
  logic [18:0] lim;

  psd_pkg::state_t state, state_next;

  logic signed [15:0] y;
  logic [2:0]  nb;
  logic [4:0]  npts;
  logic [4:0]  j;
  logic [4:0]  k;
  logic [4:0]  sq;
  logic [1:0]  bi;
  logic        side;
  logic        busy;
  logic [40:0] ex [16];
  logic [40:0] emin;
  logic [40:0] r;
  logic [40:0] ex_new;
  logic [32:0] acc;
  logic [32:0] term [16];
  logic [36:0] s0, s1;
  logic [36:0] m;
  logic signed [22:0] lg [2];
  logic [5:0]  pos;
  logic [15:0] frac;
  logic signed [19:0] res;

  logic        mstart;
  logic [36:0] ma, mb;
  logic        mdone;
  logic [73:0] mp;

  psd_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  logic        wr;
  logic [1:0]  ridx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      bps         <= 3'd1;
      label_table <= 64'hFEDCBA9876543210;
      scale       <= 24'd32768;
      lim         <= 19'd102400;
    end else if (wr && paddr[2:0] == 3'd0) begin
      unique case (ridx)
        psd_pkg::RegBps:   bps         <= pwdata[2:0];
        psd_pkg::RegLabel: label_table <= pwdata;
        psd_pkg::RegScale: scale       <= pwdata[23:0];
        psd_pkg::RegLimit: lim         <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      psd_pkg::RegBps:   prdata = {61'd0, bps};
      psd_pkg::RegLabel: prdata = label_table;
      psd_pkg::RegScale: prdata = {40'd0, scale};
      psd_pkg::RegLimit: prdata = {45'd0, lim};
      default:           prdata = '0;
    endcase
  end

  // effective bits per symbol
  logic [2:0] eb;
  always_comb begin
    eb = (bps == 3'd0) ? 3'd1 : (bps > 3'd4 ? 3'd4 : bps);
    if (eb > 3'(MaxBits)) eb = 3'(MaxBits);
  end

  // point j value
  logic [4:0] half;
  logic signed [6:0] o;
  logic [5:0] oabs;
  logic signed [16:0] xj;
  logic signed [17:0] d;
  assign half = npts >> 1;
  assign o = 7'(signed'({2'b0, j})) * 7'sd2 - 7'(signed'({2'b0, npts})) + 7'sd1;
  assign oabs = o[6] ? 6'(-o) : 6'(o);
  always_comb begin
    xj = 17'(signed'({1'b0, psd_pkg::point_mag(4'(half - 5'd1 + 5'((oabs - 6'd1) >> 1)))}));
    if (o[6]) xj = -xj;
  end
  assign d = 18'(y) - 18'(xj);

  assign ex_new = 41'((mp + (74'd1 << 23)) >> 24);
  assign r = ex[j[3:0]] - emin;

  logic [3:0] lab;
  logic       lbit;
  assign lab = label_table[4*j[3:0] +: 4];
  assign lbit = lab[2'(nb - 3'd1 - 3'(bi))];

  logic [36:0] ssel;
  assign ssel = side ? s1 : s0;

  logic [5:0] msb;
  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < 37; i++) if (ssel[i]) msb = 6'(i);
  end

  logic signed [22:0] diff;
  logic [22:0] mag;
  assign diff = lg[0] - lg[1];
  assign mag = diff[22] ? 23'(-diff) : 23'(diff);

  logic [73:0] qraw;
  logic [36:0] q;
  assign qraw = (mp + (74'd1 << 37)) >> 38;
  assign q = 37'(qraw);

  always_comb begin
    state_next = state;
    unique case (state)
      psd_pkg::ST_IDLE:  if (in_valid) state_next = psd_pkg::ST_DIST;
      psd_pkg::ST_DIST:  if (mdone && side && j == npts - 5'd1) state_next = psd_pkg::ST_MIN;
      psd_pkg::ST_MIN:   state_next = psd_pkg::ST_EXP;
      psd_pkg::ST_EXP:   if (!busy && k == 5'd21 && j == npts - 5'd1)
                           state_next = psd_pkg::ST_SUM;
      psd_pkg::ST_SUM:   if (j == npts - 5'd1) state_next = psd_pkg::ST_LOGN;
      psd_pkg::ST_LOGN:  state_next = (s0 == 0 || s1 == 0) ? psd_pkg::ST_OUT
                                                            : psd_pkg::ST_LOGSQ;
      psd_pkg::ST_LOGSQ: if (mdone && sq == 5'd15)
                           state_next = side ? psd_pkg::ST_SCALE : psd_pkg::ST_LOGN;
      psd_pkg::ST_SCALE: if (mdone) state_next = psd_pkg::ST_OUT;
      psd_pkg::ST_OUT:   if (!out_valid || !out_stall)
                           state_next = (bi == 2'(nb - 3'd1)) ? psd_pkg::ST_IDLE
                                                             : psd_pkg::ST_SUM;
      default: state_next = psd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    unique case (state)
      psd_pkg::ST_DIST: begin
        mstart = !busy;
        ma = side ? 37'(ex[j[3:0]]) : 37'(d[17] ? 18'(-d) : d);
        mb = side ? 37'(scale) : 37'(d[17] ? 18'(-d) : d);
      end
      psd_pkg::ST_EXP: begin
        mstart = !busy && k < 5'd21 && r[k];
        ma = 37'(acc);
        mb = 37'(psd_pkg::exp_entry(k));
      end
      psd_pkg::ST_LOGSQ: begin
        mstart = !busy;
        ma = m;
        mb = m;
      end
      psd_pkg::ST_SCALE: begin
        mstart = !busy;
        ma = 37'(mag);
        mb = 37'(psd_pkg::Ln2Q32);
      end
      default: ;
    endcase
  end

  assign in_stall = (state != psd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psd_pkg::ST_IDLE;
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == psd_pkg::ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (mdone) busy <= 1'b0;
      else if (mstart) busy <= 1'b1;
      unique case (state)
        psd_pkg::ST_IDLE: begin
          y <= sample;
          nb <= eb;
          npts <= 5'd1 << eb;
          j <= '0;
          side <= 1'b0;
          emin <= '1;
          bi <= '0;
        end
        psd_pkg::ST_DIST: if (mdone) begin
          if (!side) ex[j[3:0]] <= 41'(mp);
          else begin
            ex[j[3:0]] <= ex_new;
            if (ex_new < emin) emin <= ex_new;
            j <= (j == npts - 5'd1) ? '0 : j + 5'd1;
          end
          side <= !side;
        end
        psd_pkg::ST_MIN: begin
          k <= '0;
          acc <= 33'h100000000;
        end
        psd_pkg::ST_EXP: begin
          if (mdone) begin
            acc <= 33'((mp + (74'd1 << 31)) >> 32);
            k <= k + 5'd1;
          end else if (!busy && k < 5'd21 && !r[k] && !mstart) k <= k + 5'd1;
          if (!busy && k == 5'd21) begin
            term[j[3:0]] <= (r >= 41'd2097152) ? 33'd0 : acc;
            k <= '0;
            acc <= 33'h100000000;
            j <= (j == npts - 5'd1) ? '0 : j + 5'd1;
            if (j == npts - 5'd1) begin
              s0 <= '0;
              s1 <= '0;
            end
          end
        end
        psd_pkg::ST_SUM: begin
          if (lbit) s1 <= s1 + 37'(term[j[3:0]]);
          else s0 <= s0 + 37'(term[j[3:0]]);
          j <= (j == npts - 5'd1) ? '0 : j + 5'd1;
          side <= 1'b0;
        end
        psd_pkg::ST_LOGN: begin
          pos <= msb;
          m <= (msb >= 6'd30) ? 37'(ssel >> (msb - 6'd30)) : 37'(ssel << (6'd30 - msb));
          frac <= '0;
          sq <= '0;
          if (s0 == 0) begin
            res <= -20'(lim);
          end else if (s1 == 0) begin
            res <= 20'(lim);
          end
        end
        psd_pkg::ST_LOGSQ: if (mdone) begin
          sq <= sq + 5'd1;
          if (((mp + (74'd1 << 29)) >> 30) >= (74'd1 << 31)) begin
            m <= 37'(((mp + (74'd1 << 29)) >> 30) >> 1);
            frac <= {frac[14:0], 1'b1};
            if (sq == 5'd15)
              lg[side] <= 23'(signed'({1'b0, pos}) - 7'sd32) * 23'sd65536
                          + 23'({frac[14:0], 1'b1});
          end else begin
            m <= 37'((mp + (74'd1 << 29)) >> 30);
            frac <= {frac[14:0], 1'b0};
            if (sq == 5'd15)
              lg[side] <= 23'(signed'({1'b0, pos}) - 7'sd32) * 23'sd65536
                          + 23'({frac[14:0], 1'b0});
          end
          if (sq == 5'd15) side <= 1'b1;
        end
        psd_pkg::ST_SCALE: if (mdone) begin
          if (q > 37'(lim)) res <= diff[22] ? -20'(lim) : 20'(lim);
          else res <= diff[22] ? -20'(q) : 20'(q);
        end
        psd_pkg::ST_OUT: if (!out_valid || !out_stall) begin
          llr <= res;
          bit_index <= bi;
          last <= (bi == 2'(nb - 3'd1));
          bi <= bi + 2'd1;
          j <= '0;
          s0 <= '0;
          s1 <= '0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != psd_pkg::ST_IDLE) |-> in_stall)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(llr) && $stable(bit_index) && $stable(last)))
    else $error("stalled transaction changed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (bit_index == 2'(nb - 3'd1)))
    else $error("last on wrong bit");
endmodule

// File: tb/sv/tb.sv
// Testbench for the M-PAM soft demapper core: directed and randomised samples checked against an LLR predictor.
module tb;

  typedef struct {
    logic signed [19:0] llr;
    logic [1:0]         bit_index;
    logic               last;
  } llr_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [19:0] llr;
  logic [1:0]         bit_index;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  pam_soft_demapper_llr_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [2:0]  m_bps = 3'd1;
  logic [63:0] m_label = 64'hFEDCBA9876543210;
  logic [23:0] m_scale = 24'd32768;
  logic [18:0] m_limit = 19'd102400;

  longint unsigned exp_tab[21];
  logic signed [15:0] pending_samples[$];
  llr_t expected_llrs[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit in_taken = 1'b0;

  function automatic void build_exp_tab();
    logic [63:0]  c;
    logic [127:0] p;
    c = (64'd1 << 62) - (64'd1 << 46) + (64'd1 << 29) - 64'd2731;
    for (int k = 0; k < 21; k++) begin
      exp_tab[k] = (c + (64'd1 << 29)) >> 30;
      p = {64'd0, c} * {64'd0, c};
      c = p[125:62] + {63'd0, p[61]};
    end
  endfunction

  function automatic longint unsigned exp_neg_q32(longint unsigned r);
    longint unsigned acc;
    acc = 64'd1 << 32;
    if (r >= (64'd1 << 21)) return 0;
    for (int k = 0; k < 21; k++)
      if (r[k]) acc = (acc * exp_tab[k] + (64'd1 << 31)) >> 32;
    return acc;
  endfunction

  function automatic longint log2_q16(longint unsigned s);
    int p;
    longint unsigned m;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && s[p] == 1'b0) p--;
    if (p >= 30) m = s >> (p - 30);
    else m = s << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m + (64'd1 << 29)) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p - 32) * 65536 + frac;
  endfunction

  task automatic predict_llrs(input logic signed [15:0] y);
    longint unsigned ex[16], term[16], emin, s0, s1, mag, q, d2;
    longint d, diff, res, lim;
    int b, npts, half, o, x;
    llr_t r;
    emin = 64'hFFFF_FFFF_FFFF_FFFF;
    lim = longint'(m_limit);
    b = (m_bps == 0) ? 1 : (m_bps > 4) ? 4 : int'(m_bps);
    npts = 1 << b;
    half = npts / 2;
    for (int j = 0; j < npts; j++) begin
      o = 2 * j - npts + 1;
      x = int'(psd_pkg::point_mag(4'(half - 1 + ((o < 0 ? -o : o) - 1) / 2)));
      if (o < 0) x = -x;
      d = longint'(y) - x;
      d2 = longint'(d * d);
      ex[j] = (d2 * longint'(m_scale) + (64'd1 << 23)) >> 24;
      if (ex[j] < emin) emin = ex[j];
    end
    for (int j = 0; j < npts; j++) term[j] = exp_neg_q32(ex[j] - emin);
    for (int i = 0; i < b; i++) begin
      s0 = 0;
      s1 = 0;
      for (int j = 0; j < npts; j++)
        if (m_label[4 * j + (b - 1 - i)]) s1 += term[j];
        else s0 += term[j];
      if (s0 == 0) res = -lim;
      else if (s1 == 0) res = lim;
      else begin
        diff = log2_q16(s0) - log2_q16(s1);
        mag = diff < 0 ? -diff : diff;
        q = (mag * psd_pkg::Ln2Q32 + (64'd1 << 37)) >> 38;
        if (q > lim) q = lim;
        res = diff < 0 ? -longint'(q) : longint'(q);
      end
      r.llr = res[19:0];
      r.bit_index = 2'(i);
      r.last = (i == b - 1);
      expected_llrs.push_back(r);
    end
  endtask

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (!in_valid || in_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
          sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    llr_t e;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        predict_llrs(sample);
      end
      if (out_valid && !out_stall) begin
        if (expected_llrs.size() == 0) report("unexpected transaction");
        else begin
          e = expected_llrs.pop_front();
          if (llr !== e.llr)
            report($sformatf("llr %0d, want %0d", llr, e.llr));
          if (bit_index !== e.bit_index)
            report($sformatf("bit_index %0d, want %0d", bit_index, e.bit_index));
          if (last !== e.last)
            report($sformatf("last %0b, want %0b", last, e.last));
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 3;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      psd_pkg::RegBps:   m_bps = value[2:0];
      psd_pkg::RegLabel: m_label = value;
      psd_pkg::RegScale: m_scale = value[23:0];
      psd_pkg::RegLimit: m_limit = value[18:0];
    endcase
  endtask

  task automatic set_all(input logic [63:0] bps, input logic [63:0] lab,
                         input logic [63:0] scl, input logic [63:0] lim);
    write_reg(psd_pkg::RegBps, bps);
    write_reg(psd_pkg::RegLabel, lab);
    write_reg(psd_pkg::RegScale, scl);
    write_reg(psd_pkg::RegLimit, lim);
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid && expected_llrs.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_samples(input int n);
    int pt;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(2) == 0) pending_samples.push_back(16'($urandom));
      else begin
        pt = int'(psd_pkg::point_mag(4'($urandom_range(14))));
        if ($urandom_range(1)) pt = -pt;
        pending_samples.push_back(16'(pt + int'($urandom_range(1600)) - 800));
      end
    end
  endtask

  initial begin
    logic [63:0] lab;
    logic signed [15:0] corner [6];
    corner = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd4096, -16'sd4096};
    build_exp_tab();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 20;
    recv_idle = 64;

    // reset settings, field extremes
    foreach (corner[i])
      pending_samples.push_back(corner[i]);
    drain();
    // 16-PAM, strongest scale, widest limit
    set_all(64'd4, 64'hFEDCBA9876543210, 64'hFFFFFF, 64'h7FFFF);
    pending_samples.push_back(16'sd6664);
    pending_samples.push_back(-16'sd6664);
    pending_samples.push_back(16'sd100);
    pending_samples.push_back(16'sd32767);
    drain();
    // zero scale with a reversed label table: LLR is ln of count ratio
    set_all(64'd3, 64'h0000_0000_0123_4567, 64'd0, 64'd102400);
    pending_samples.push_back(16'sd1000);
    pending_samples.push_back(-16'sd20000);
    drain();
    // empty sums: all-zero labels, then all-ones labels
    set_all(64'd2, 64'd0, 64'd32768, 64'd5000);
    pending_samples.push_back(16'sd300);
    drain();
    write_reg(psd_pkg::RegLabel, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_samples.push_back(-16'sd300);
    drain();
    // out-of-range widths, zero limit
    set_all(64'd0, 64'hFEDCBA9876543210, 64'd65536, 64'd0);
    pending_samples.push_back(16'sd2000);
    pending_samples.push_back(-16'sd2000);
    drain();
    write_reg(psd_pkg::RegBps, 64'd7);
    write_reg(psd_pkg::RegLimit, 64'd102400);
    pending_samples.push_back(16'sd1333);
    pending_samples.push_back(-16'sd5776);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 20 : (ph < 4) ? 64 : 0;
      recv_idle = (ph < 2) ? 64 : (ph < 4) ? 20 : 0;
      lab = {$urandom, $urandom};
      if (ph % 2 == 0) lab = 64'hFEDCBA9876543210 ^ {16{4'($urandom_range(15))}};
      set_all(64'($urandom_range(7)), lab,
              (ph == 5) ? 64'hFFFFFF : 64'($urandom_range(24'hFFFFFF) >> $urandom_range(12)),
              64'($urandom_range(19'h7FFFF)) | {$urandom, $urandom} << 19);
      queue_samples(24);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
